@@ rtl/rwsp_pkg.sv @@
// Shared types and constants of the RIFF/WAVE stream parser.
`default_nettype none

package rwsp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHDR,
        PH_FMT,
        PH_DATA,
        PH_SMPL,
        PH_SKIP,
        PH_PAD,
        PH_DONE
    } phase_t;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_SMPL = 32'h6C70_6D73;

    localparam logic [15:0] FMT_PCM = 16'd1;
    localparam logic [31:0] SMPL_MIN_SIZE = 32'd36;
    localparam logic [32:0] CONSUMED_MAX = 33'h1_FFFF_FFFF;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_LOOP   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_MISSING    = 2'd2;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [24:0] sample;
        logic [31:0] sample_rate;
        logic [15:0] channels;
        logic [15:0] bit_depth;
        logic [31:0] loop_start;
        logic [31:0] loop_end;
        logic        has_loop;
        logic [1:0]  status;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/riff_wave_stream_parser_unit.sv @@
// RIFF/WAVE byte stream parser: header check, chunk walk, fmt/smpl reports, PCM samples.
//
// Usage: file bytes enter on the request channel (in_valid/in_ready, in_byte,
// end_of_stream set on the final byte). Results leave on the result channel
// (out_valid/out_ready): kind selects a mono Q1.24 sample, the PCM format,
// the first sampler loop or the final status; unused fields read zero and
// last marks the final result caused by one request.
// Each request is parsed in the cycle it is accepted; its results are
// written into a four-entry result queue whose head drives the outputs.
// Throughput: one request per cycle while the receiver takes every result and
// each request yields at most one result; a request that yields two results
// (sample or report plus status) leaves two queue entries. in_ready is high
// while the queue has room for two results, so a stalled receiver stops intake
// once three or four results wait, and no result is ever lost or repeated.
// Reset: the parser returns to the header phase with its state registers clear and
// the result queue empty; the pending fmt/smpl fields and the frame are not reset.
// The end_of_stream request returns the parser to that state after its status result.
`default_nettype none

module riff_wave_stream_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               end_of_stream,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic signed [24:0] sample,
    output logic [31:0]        sample_rate,
    output logic [15:0]        channels,
    output logic [15:0]        bit_depth,
    output logic [31:0]        loop_start,
    output logic [31:0]        loop_end,
    output logic               has_loop,
    output logic [1:0]         status,
    output logic               last
);
    import rwsp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [5:0]        idx_reg, idx_next;
    logic [31:0]       tag_reg, tag_next;
    logic [31:0]       fasm_reg, fasm_next;
    logic [32:0]       riff_end_reg, riff_end_next;
    logic [32:0]       consumed_reg, consumed_next;
    logic [31:0]       remaining_reg, remaining_next;
    logic              pad_reg, pad_next;
    logic              fmt_seen_reg, fmt_seen_next;
    logic              data_seen_reg, data_seen_next;
    logic [15:0]       ch_reg, ch_next;
    logic [15:0]       depth_reg, depth_next;
    logic              failed_reg, failed_next;
    logic [15:0]       pend_ch_reg, pend_ch_next;
    logic [31:0]       pend_rate_reg, pend_rate_next;
    logic [31:0]       pend_ls_reg, pend_ls_next;
    logic              loop_nz_reg, loop_nz_next;
    logic [5:0][7:0]   frame_reg, frame_next;

    res_t                      fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]          count_reg, count_next;

    logic              accept;
    logic              pop;
    logic [31:0]       byte_lane;
    logic [31:0]       fa;
    logic [31:0]       rem;
    logic              r0_valid;
    res_t              r0;
    res_t              r1;
    res_t              e0;
    logic [1:0]        push_n;
    logic [5:0][7:0]   frame_cur;
    logic [2:0]        flen_m1;
    logic              is16;
    logic              stereo;
    logic signed [15:0] s16a, s16b;
    logic signed [23:0] s24a, s24b;
    logic [16:0]       sum16;
    logic [24:0]       sum24;
    logic [24:0]       smp;
    res_t              head;

    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign byte_lane = {24'd0, in_byte} << {idx_reg[1:0], 3'b000};

    // Frame assembly and sample scaling
    always_comb
    begin
        frame_cur = frame_reg;
        if (idx_reg[2:0] < 3'd6)
        begin
            frame_cur[idx_reg[2:0]] = in_byte;
        end
        is16   = (depth_reg == 16'd16);
        stereo = (ch_reg == 16'd2);
        case ({is16, stereo})
            2'b10:   flen_m1 = 3'd1;
            2'b11:   flen_m1 = 3'd3;
            2'b00:   flen_m1 = 3'd2;
            default: flen_m1 = 3'd5;
        endcase
        s16a  = {frame_cur[1], frame_cur[0]};
        s16b  = {frame_cur[3], frame_cur[2]};
        s24a  = {frame_cur[2], frame_cur[1], frame_cur[0]};
        s24b  = {frame_cur[5], frame_cur[4], frame_cur[3]};
        sum16 = {s16a[15], s16a} + {s16b[15], s16b};
        sum24 = {s24a[23], s24a} + {s24b[23], s24b};
        case ({is16, stereo})
            2'b10:   smp = {s16a, 9'd0};
            2'b11:   smp = {sum16, 8'd0};
            2'b00:   smp = {s24a, 1'b0};
            default: smp = sum24;
        endcase
    end

    // Parser next state and results
    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        tag_next       = tag_reg;
        fasm_next      = fasm_reg;
        riff_end_next  = riff_end_reg;
        consumed_next  = consumed_reg;
        remaining_next = remaining_reg;
        pad_next       = pad_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        ch_next        = ch_reg;
        depth_next     = depth_reg;
        failed_next    = failed_reg;
        pend_ch_next   = pend_ch_reg;
        pend_rate_next = pend_rate_reg;
        pend_ls_next   = pend_ls_reg;
        loop_nz_next   = loop_nz_reg;
        frame_next     = frame_reg;
        fa             = fasm_reg;
        rem            = remaining_reg;
        r0_valid       = 1'b0;
        r0             = '0;
        r1             = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    fa = ((idx_reg[1:0] == 2'd0) ? 32'd0 : fasm_reg) | byte_lane;
                    fasm_next = fa;
                    if (idx_reg == 6'd3 && fa != TAG_RIFF)
                    begin
                        failed_next = 1'b1;
                        phase_next  = PH_DONE;
                    end
                    else if (idx_reg == 6'd7)
                    begin
                        riff_end_next = {1'b0, fa} + 33'd8;
                    end
                    else if (idx_reg == 6'd11)
                    begin
                        if (fa != TAG_WAVE)
                        begin
                            failed_next = 1'b1;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_CHDR;
                            fasm_next  = '0;
                        end
                    end
                    idx_next = (phase_next == PH_HEADER) ? idx_reg + 6'd1 : 6'd0;
                end
                PH_CHDR:
                begin
                    if (idx_reg == 6'd0 && consumed_reg >= riff_end_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (idx_reg < 6'd4)
                        begin
                            tag_next = ((idx_reg == 6'd0) ? 32'd0 : tag_reg) | byte_lane;
                        end
                        else
                        begin
                            fa = ((idx_reg == 6'd4) ? 32'd0 : fasm_reg) | byte_lane;
                            fasm_next = fa;
                        end
                        idx_next = idx_reg + 6'd1;
                        if (idx_reg == 6'd7)
                        begin
                            remaining_next = fa;
                            pad_next       = fa[0];
                            idx_next       = '0;
                            fasm_next      = '0;
                            if (tag_reg == TAG_FMT)
                            begin
                                phase_next = PH_FMT;
                            end
                            else if (tag_reg == TAG_DATA && fmt_seen_reg &&
                                     (depth_reg == 16'd16 || depth_reg == 16'd24))
                            begin
                                data_seen_next = 1'b1;
                                phase_next = (ch_reg == 16'd1 || ch_reg == 16'd2) ?
                                             PH_DATA : PH_SKIP;
                            end
                            else if (tag_reg == TAG_SMPL && fa >= SMPL_MIN_SIZE)
                            begin
                                phase_next = PH_SMPL;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                            if (fa == 32'd0)
                            begin
                                phase_next = PH_CHDR;
                            end
                        end
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_CHDR;
                    idx_next   = '0;
                end
                PH_FMT, PH_DATA, PH_SMPL, PH_SKIP:
                begin
                    rem = remaining_reg - 32'd1;
                    remaining_next = rem;
                    case (phase_reg)
                        PH_FMT:
                        begin
                            case (idx_reg)
                                6'd0:
                                begin
                                    fasm_next = {24'd0, in_byte};
                                end
                                6'd1:
                                begin
                                    fasm_next = {16'd0, in_byte, fasm_reg[7:0]};
                                    if ({in_byte, fasm_reg[7:0]} != FMT_PCM)
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                                6'd2:
                                begin
                                    pend_ch_next = {8'd0, in_byte};
                                end
                                6'd3:
                                begin
                                    pend_ch_next = {in_byte, pend_ch_reg[7:0]};
                                end
                                6'd4, 6'd5, 6'd6, 6'd7:
                                begin
                                    pend_rate_next = ((idx_reg == 6'd4) ? 32'd0 : pend_rate_reg)
                                                     | byte_lane;
                                end
                                6'd14:
                                begin
                                    fasm_next = {24'd0, in_byte};
                                end
                                6'd15:
                                begin
                                    fasm_next      = {16'd0, in_byte, fasm_reg[7:0]};
                                    fmt_seen_next  = 1'b1;
                                    ch_next        = pend_ch_reg;
                                    depth_next     = {in_byte, fasm_reg[7:0]};
                                    r0_valid       = 1'b1;
                                    r0.kind        = KIND_FORMAT;
                                    r0.sample_rate = pend_rate_reg;
                                    r0.channels    = pend_ch_reg;
                                    r0.bit_depth   = {in_byte, fasm_reg[7:0]};
                                    phase_next     = PH_SKIP;
                                end
                                default:
                                begin
                                    fasm_next = fasm_reg;
                                end
                            endcase
                            idx_next = idx_reg + 6'd1;
                        end
                        PH_DATA:
                        begin
                            frame_next = frame_cur;
                            if (idx_reg == {3'd0, flen_m1})
                            begin
                                r0_valid  = 1'b1;
                                r0.kind   = KIND_SAMPLE;
                                r0.sample = smp;
                                idx_next  = '0;
                            end
                            else
                            begin
                                idx_next = idx_reg + 6'd1;
                            end
                        end
                        PH_SMPL:
                        begin
                            if (idx_reg >= 6'd28 && idx_reg <= 6'd31)
                            begin
                                loop_nz_next = ((idx_reg == 6'd28) ? 1'b0 : loop_nz_reg) |
                                               (in_byte != 8'd0);
                            end
                            else if (idx_reg >= 6'd40 && idx_reg <= 6'd43)
                            begin
                                pend_ls_next = ((idx_reg == 6'd40) ? 32'd0 : pend_ls_reg) |
                                               byte_lane;
                            end
                            else if (idx_reg >= 6'd44 && idx_reg <= 6'd47)
                            begin
                                fa = ((idx_reg == 6'd44) ? 32'd0 : fasm_reg) | byte_lane;
                                fasm_next = fa;
                                if (idx_reg == 6'd47)
                                begin
                                    if (loop_nz_reg)
                                    begin
                                        r0_valid      = 1'b1;
                                        r0.kind       = KIND_LOOP;
                                        r0.loop_start = pend_ls_reg;
                                        r0.loop_end   = fa;
                                        r0.has_loop   = 1'b1;
                                    end
                                    phase_next = PH_SKIP;
                                end
                            end
                            if (idx_reg == 6'd31 && !loop_nz_next)
                            begin
                                phase_next = PH_SKIP;
                            end
                            idx_next = idx_reg + 6'd1;
                        end
                        default:
                        begin
                            idx_next = idx_reg;
                        end
                    endcase
                    if (rem == 32'd0)
                    begin
                        phase_next = pad_reg ? PH_PAD : PH_CHDR;
                        idx_next   = '0;
                        fasm_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (consumed_reg < CONSUMED_MAX)
            begin
                consumed_next = consumed_reg + 33'd1;
            end

            if (end_of_stream)
            begin
                r1.kind = KIND_STATUS;
                r1.last = 1'b1;
                if (failed_next || phase_next == PH_HEADER)
                begin
                    r1.status = ST_BAD_HEADER;
                end
                else if (!(fmt_seen_next && data_seen_next))
                begin
                    r1.status = ST_MISSING;
                end
                else
                begin
                    r1.status = ST_OK;
                end
                // drop all file state for the next file
                phase_next     = PH_HEADER;
                idx_next       = '0;
                tag_next       = '0;
                fasm_next      = '0;
                riff_end_next  = 33'd8;
                consumed_next  = '0;
                remaining_next = '0;
                pad_next       = 1'b0;
                fmt_seen_next  = 1'b0;
                data_seen_next = 1'b0;
                ch_next        = '0;
                depth_next     = '0;
                failed_next    = 1'b0;
            end
            else
            begin
                r0.last = 1'b1;
            end
        end
    end

    // Result queue
    always_comb
    begin
        e0          = r0_valid ? r0 : r1;
        push_n      = accept ? ({1'b0, r0_valid} + {1'b0, end_of_stream}) : 2'd0;
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            idx_reg       <= '0;
            tag_reg       <= '0;
            fasm_reg      <= '0;
            riff_end_reg  <= 33'd8;
            consumed_reg  <= '0;
            remaining_reg <= '0;
            pad_reg       <= 1'b0;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            ch_reg        <= '0;
            depth_reg     <= '0;
            failed_reg    <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            tag_reg       <= tag_next;
            fasm_reg      <= fasm_next;
            riff_end_reg  <= riff_end_next;
            consumed_reg  <= consumed_next;
            remaining_reg <= remaining_next;
            pad_reg       <= pad_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            ch_reg        <= ch_next;
            depth_reg     <= depth_next;
            failed_reg    <= failed_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ch_reg   <= pend_ch_next;
        pend_rate_reg <= pend_rate_next;
        pend_ls_reg   <= pend_ls_next;
        loop_nz_reg   <= loop_nz_next;
        frame_reg     <= frame_next;
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= e0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= r1;
        end
    end

    assign head        = fifo_reg[rd_ptr_reg];
    assign kind        = head.kind;
    assign sample      = head.sample;
    assign sample_rate = head.sample_rate;
    assign channels    = head.channels;
    assign bit_depth   = head.bit_depth;
    assign loop_start  = head.loop_start;
    assign loop_end    = head.loop_end;
    assign has_loop    = head.has_loop;
    assign status      = head.status;
    assign last        = head.last;

endmodule

`default_nettype wire
